// ===== hw/rtl/mmr_pkg.sv =====
// mmr_pkg: shared constants, codes, queue entry type and size clamp for the
// row-streaming matrix multiplier. No dependencies.
package mmr_pkg;

	localparam int DEF_MAX_INNER = 16;
	localparam int DEF_MAX_COLS = 16;
	localparam int QUEUE_DEPTH = 4;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;
	localparam int ELEM_W = 16;
	localparam int SUM_W = 36;
	localparam int COL_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_A = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_B = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 2'd3;

	localparam logic OP_LOAD_B = 1'b0;
	localparam logic OP_STREAM_A = 1'b1;

	typedef struct packed {
		logic is_err;
		logic last_row;
	} job_t;

	// zero counts as one, large values saturate to the maximum
	function automatic logic [6:0] clamp_size(input logic [4:0] v, input logic [6:0] maxv);
		logic [6:0] r;
		r = {2'b00, v};
		if (v == 5'd0)
			r = 7'd1;
		else if (r > maxv)
			r = maxv;
		return r;
	endfunction

endpackage

// ===== hw/rtl/mmr_if.sv =====
// mmr_in_if / mmr_out_if: valid-ready channels of the matrix multiplier.
// No dependencies.
interface mmr_in_if;
	logic valid;
	logic ready;
	logic opcode;
	logic signed [15:0] element_value;

	modport source(output valid, output opcode, output element_value, input ready);
	modport sink(input valid, input opcode, input element_value, output ready);
endinterface

interface mmr_out_if;
	logic valid;
	logic ready;
	logic signed [35:0] product_sum;
	logic [3:0] column_index;
	logic last_of_row;
	logic last_of_matrix;
	logic size_error;

	modport source(output valid, output product_sum, output column_index,
		output last_of_row, output last_of_matrix, output size_error, input ready);
	modport sink(input valid, input product_sum, input column_index,
		input last_of_row, input last_of_matrix, input size_error, output ready);
endinterface

// ===== hw/rtl/mmr_queue.sv =====
// mmr_queue: small job queue between front and back parts.
// Depends on mmr_pkg (job_t).
module mmr_queue import mmr_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t head,
	output logic full,
	output logic empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t slots_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("job queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("job queue underflow");

endmodule

// ===== hw/rtl/mmr_front.sv =====
// mmr_front: accepts requests, writes right-matrix and left-row elements,
// tracks positions and queues row and error jobs. Depends on mmr_pkg, mmr_if.
module mmr_front import mmr_pkg::*; #(
	parameter int MAX_INNER = DEF_MAX_INNER,
	parameter int MAX_COLS = DEF_MAX_COLS,
	localparam int IW = $clog2(MAX_INNER + 1),
	localparam int LW = $clog2(MAX_INNER * MAX_COLS + 1),
	localparam int LAW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1,
	localparam int AW = (MAX_INNER * MAX_COLS > 1) ? $clog2(MAX_INNER * MAX_COLS) : 1
) (
	input  logic clk,
	input  logic arst_n,
	mmr_in_if.sink items,
	input  logic [IW-1:0] inner_c,
	input  logic [LW-1:0] limit,
	input  logic [7:0] rows_c,
	input  logic mismatch,
	output logic q_push,
	output job_t q_job,
	input  logic q_full,
	input  logic row_done,
	output logic left_we,
	output logic [LAW-1:0] left_addr,
	output logic signed [ELEM_W-1:0] left_data,
	output logic store_we,
	output logic [AW-1:0] store_addr,
	output logic signed [ELEM_W-1:0] store_data
);

	logic [LW-1:0] rlp_q, rlp_cur, rlp_inc, rlp_nxt;
	logic [IW-1:0] lcp_q, lcp_cur, lcp_inc;
	logic [7:0] rc_q, rc_cur, rc_inc, rc_nxt;
	logic row_busy_q;
	logic accept, is_b, a_ok, row_end, last_row;

	assign items.ready = !q_full && !row_busy_q;
	assign accept = items.valid && items.ready;
	assign is_b = (items.opcode == OP_LOAD_B);
	assign a_ok = accept && !is_b && !mismatch;

	assign rlp_cur = (rlp_q >= limit) ? '0 : rlp_q;
	assign rlp_inc = rlp_cur + 1'b1;
	assign rlp_nxt = (rlp_inc >= limit) ? '0 : rlp_inc;

	assign lcp_cur = (lcp_q >= inner_c) ? '0 : lcp_q;
	assign lcp_inc = lcp_cur + 1'b1;
	assign row_end = (lcp_inc >= inner_c);

	assign rc_cur = (rc_q >= rows_c) ? '0 : rc_q;
	assign rc_inc = rc_cur + 1'b1;
	assign rc_nxt = (rc_inc >= rows_c) ? '0 : rc_inc;
	assign last_row = (rc_cur == rows_c - 1'b1);

	assign store_we = accept && is_b;
	assign store_addr = AW'(rlp_cur);
	assign store_data = items.element_value;
	assign left_we = a_ok;
	assign left_addr = LAW'(lcp_cur);
	assign left_data = items.element_value;

	assign q_push = (accept && !is_b && mismatch) || (a_ok && row_end);
	assign q_job.is_err = mismatch;
	assign q_job.last_row = last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rlp_q <= '0;
			lcp_q <= '0;
			rc_q <= '0;
			row_busy_q <= 1'b0;
		end else begin
			if (store_we)
				rlp_q <= rlp_nxt;
			if (a_ok)
				lcp_q <= row_end ? '0 : lcp_inc;
			if (a_ok && row_end) begin
				rc_q <= rc_nxt;
				row_busy_q <= 1'b1;
			end else if (row_done) begin
				row_busy_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/mmr_back.sv =====
// mmr_back: holds the matrix memories, runs the shared multiply-accumulate over each
// queued row one column at a time and answers error jobs. Depends on mmr_pkg, mmr_if.
module mmr_back import mmr_pkg::*; #(
	parameter int MAX_INNER = DEF_MAX_INNER,
	parameter int MAX_COLS = DEF_MAX_COLS,
	localparam int IW = $clog2(MAX_INNER + 1),
	localparam int CW = $clog2(MAX_COLS + 1),
	localparam int LAW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1,
	localparam int AW = (MAX_INNER * MAX_COLS > 1) ? $clog2(MAX_INNER * MAX_COLS) : 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [IW-1:0] inner_c,
	input  logic [CW-1:0] cols_c,
	input  job_t job,
	input  logic q_empty,
	output logic q_pop,
	output logic row_done,
	input  logic left_we,
	input  logic [LAW-1:0] left_addr,
	input  logic signed [ELEM_W-1:0] left_data,
	input  logic store_we,
	input  logic [AW-1:0] store_addr,
	input  logic signed [ELEM_W-1:0] store_data,
	mmr_out_if.source results
);

	localparam int JW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int SW = AW + CW;
	localparam int ACC_W = (33 + $clog2(MAX_INNER) > SUM_W) ? 33 + $clog2(MAX_INNER) : SUM_W;
	localparam logic signed [SUM_W-1:0] SUM_HI = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_LO = {1'b1, {(SUM_W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(SUM_HI);
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(SUM_LO);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_ERR = 2'd3;

	logic signed [ELEM_W-1:0] left_mem [MAX_INNER];
	logic signed [ELEM_W-1:0] store_mem [MAX_INNER * MAX_COLS];

	logic [1:0] state_q;
	logic [LAW-1:0] k_q;
	logic [JW-1:0] j_q;
	logic [AW-1:0] addr_q;
	logic last_row_q;

	logic v_s1, first_s1, last_s1;
	logic signed [ELEM_W-1:0] left_s1, store_s1;
	logic v_s2, first_s2, last_s2;
	logic signed [31:0] prod_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic sum_ready_q;

	logic res_valid_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [COL_IDX_W-1:0] col_q;
	logic lor_q, lom_q, err_q;

	logic issue, k_first, k_last, j_last, out_free, move_col, move_err;
	logic signed [SUM_W-1:0] sat_sum;
	logic [JW+COL_IDX_W-1:0] j_ext;

	assign issue = (state_q == ST_ISSUE);
	assign k_first = (k_q == '0);
	assign k_last = ((IW'(k_q) + 1'b1) == inner_c);
	assign j_last = ((CW'(j_q) + 1'b1) == cols_c);
	assign out_free = !res_valid_q || results.ready;
	assign move_col = (state_q == ST_DRAIN) && sum_ready_q && out_free;
	assign move_err = (state_q == ST_ERR) && out_free;
	assign q_pop = (state_q == ST_IDLE) && !q_empty;
	assign row_done = move_col && j_last;
	assign j_ext = (JW + COL_IDX_W)'(j_q);

	always_comb begin
		if (acc_q > SAT_HI)
			sat_sum = SUM_HI;
		else if (acc_q < SAT_LO)
			sat_sum = SUM_LO;
		else
			sat_sum = acc_q[SUM_W-1:0];
	end

	// memories
	always_ff @(posedge clk) begin
		if (left_we)
			left_mem[left_addr] <= left_data;
		left_s1 <= left_mem[k_q];
	end

	always_ff @(posedge clk) begin
		if (store_we)
			store_mem[store_addr] <= store_data;
		store_s1 <= store_mem[addr_q];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= '0;
			j_q <= '0;
			addr_q <= '0;
			last_row_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						last_row_q <= job.last_row;
						k_q <= '0;
						j_q <= '0;
						addr_q <= '0;
						state_q <= job.is_err ? ST_ERR : ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					k_q <= k_q + 1'b1;
					addr_q <= AW'(SW'(addr_q) + SW'(cols_c));
					if (k_last)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (move_col) begin
						if (j_last) begin
							state_q <= ST_IDLE;
						end else begin
							j_q <= j_q + 1'b1;
							k_q <= '0;
							addr_q <= AW'(j_q + 1'b1);
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_ERR: begin
					if (move_err)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// multiply-accumulate pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			first_s1 <= 1'b0;
			last_s1 <= 1'b0;
			v_s2 <= 1'b0;
			first_s2 <= 1'b0;
			last_s2 <= 1'b0;
			sum_ready_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			first_s1 <= issue && k_first;
			last_s1 <= issue && k_last;
			v_s2 <= v_s1;
			first_s2 <= first_s1;
			last_s2 <= last_s1;
			if (move_col)
				sum_ready_q <= 1'b0;
			else if (v_s2 && last_s2)
				sum_ready_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= left_s1 * store_s1;
		if (v_s2)
			acc_q <= first_s2 ? ACC_W'(prod_s2) : acc_q + ACC_W'(prod_s2);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (move_col || move_err)
			res_valid_q <= 1'b1;
		else if (results.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (move_col) begin
			sum_q <= sat_sum;
			col_q <= j_ext[COL_IDX_W-1:0];
			lor_q <= j_last;
			lom_q <= j_last && last_row_q;
			err_q <= 1'b0;
		end else if (move_err) begin
			sum_q <= '0;
			col_q <= '0;
			lor_q <= 1'b0;
			lom_q <= 1'b0;
			err_q <= 1'b1;
		end
	end

	assign results.valid = res_valid_q;
	assign results.product_sum = sum_q;
	assign results.column_index = col_q;
	assign results.last_of_row = lor_q;
	assign results.last_of_matrix = lom_q;
	assign results.size_error = err_q;

	a_mem_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE || state_q == ST_DRAIN) |-> !left_we && !store_we)
		else $error("matrix memory written during a row");

	a_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		row_done |=> res_valid_q && lor_q && !err_q)
		else $error("row finished without last-of-row result");

	a_last_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && last_s2) |-> (state_q == ST_DRAIN) && !sum_ready_q)
		else $error("final product outside drain");

endmodule

// ===== hw/rtl/matrix_multiply_rows.sv =====
// matrix_multiply_rows: top level, configuration registers, front, job queue
// and back. Depends on mmr_pkg, mmr_if, mmr_queue, mmr_front, mmr_back.
//
// items: valid-ready request channel. opcode load_b writes the next element
// of B (row-major), one request per cycle while ready is high. opcode
// stream_a writes the next element of the current row of A; when a row completes,
// ready drops until all its results have moved to the output register.
// results: valid-ready channel, one result per column of B, in column order.
// The single multiply-accumulate unit works the columns of a row in turn: the
// sequencer issues the inner memory reads of a column, each product passes
// the memory read register and the product register into the accumulator,
// and the saturated sum then moves to the result register.
// With inner sizes configured unequal, each A request gives one error result
// and changes no position.
// cfg_we / cfg_index / cfg_data write rows_a, inner_a, inner_b, cols_b.
// Reset sets the registers to 1, 16, 16, 16 and clears all positions; the
// matrix memories are not cleared. A stalled receiver holds the result
// register and the multiply-accumulate sequencer waits on it.
module matrix_multiply_rows import mmr_pkg::*; #(
	parameter int MAX_INNER = DEF_MAX_INNER,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  logic clk,
	input  logic arst_n,
	mmr_in_if.sink items,
	mmr_out_if.source results,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IW = $clog2(MAX_INNER + 1);
	localparam int CW = $clog2(MAX_COLS + 1);
	localparam int LW = $clog2(MAX_INNER * MAX_COLS + 1);
	localparam int LAW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
	localparam int AW = (MAX_INNER * MAX_COLS > 1) ? $clog2(MAX_INNER * MAX_COLS) : 1;

	logic [7:0] rows_a_q;
	logic [4:0] inner_a_q, inner_b_q, cols_b_q;

	logic [IW-1:0] inner_c, inner_b_c;
	logic [CW-1:0] cols_c;
	logic [IW+CW-1:0] limit_full;
	logic [LW-1:0] limit;
	logic [7:0] rows_c;
	logic mismatch;

	logic q_push, q_pop, q_full, q_empty, row_done;
	job_t q_job, q_head;
	logic left_we, store_we;
	logic [LAW-1:0] left_addr;
	logic [AW-1:0] store_addr;
	logic signed [ELEM_W-1:0] left_data, store_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= 8'd1;
			inner_a_q <= 5'd16;
			inner_b_q <= 5'd16;
			cols_b_q <= 5'd16;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROWS_A: rows_a_q <= cfg_data;
				REG_INNER_A: inner_a_q <= cfg_data[4:0];
				REG_INNER_B: inner_b_q <= cfg_data[4:0];
				REG_COLS_B: cols_b_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign inner_c = IW'(clamp_size(inner_a_q, 7'(MAX_INNER)));
	assign inner_b_c = IW'(clamp_size(inner_b_q, 7'(MAX_INNER)));
	assign cols_c = CW'(clamp_size(cols_b_q, 7'(MAX_COLS)));
	assign limit_full = (IW + CW)'(inner_b_c) * (IW + CW)'(cols_c);
	assign limit = LW'(limit_full);
	assign rows_c = (rows_a_q == 8'd0) ? 8'd1 : rows_a_q;
	assign mismatch = (inner_a_q != inner_b_q);

	mmr_front #(
		.MAX_INNER(MAX_INNER),
		.MAX_COLS(MAX_COLS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.items(items),
		.inner_c(inner_c),
		.limit(limit),
		.rows_c(rows_c),
		.mismatch(mismatch),
		.q_push(q_push),
		.q_job(q_job),
		.q_full(q_full),
		.row_done(row_done),
		.left_we(left_we),
		.left_addr(left_addr),
		.left_data(left_data),
		.store_we(store_we),
		.store_addr(store_addr),
		.store_data(store_data)
	);

	mmr_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_job(q_job),
		.pop(q_pop),
		.head(q_head),
		.full(q_full),
		.empty(q_empty)
	);

	mmr_back #(
		.MAX_INNER(MAX_INNER),
		.MAX_COLS(MAX_COLS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.inner_c(inner_c),
		.cols_c(cols_c),
		.job(q_head),
		.q_empty(q_empty),
		.q_pop(q_pop),
		.row_done(row_done),
		.left_we(left_we),
		.left_addr(left_addr),
		.left_data(left_data),
		.store_we(store_we),
		.store_addr(store_addr),
		.store_data(store_data),
		.results(results)
	);

endmodule

// ===== tb/matrix_multiply_rows_tb.sv =====
`timescale 1ns / 1ps
// matrix_multiply_rows_tb: self-checking bench for the row-streaming matrix multiplier,
// directed table then randomized phases over sizes and handshake stalls.
// Depends on mmr_pkg, mmr_if and matrix_multiply_rows.
module matrix_multiply_rows_tb;
	import mmr_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned RANDOM_REQUESTS = 350;
	localparam int unsigned SETTLE_CYCLES = 40;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [COL_IDX_W-1:0] col;
		logic row_end;
		logic matrix_end;
		logic err;
	} product_t;

	typedef enum logic [1:0] {ROW_WRITE, ROW_REQUEST, ROW_KNOWN} row_kind_e;

	typedef struct packed {
		row_kind_e kind;
		logic [CFG_IDX_W-1:0] index;
		logic op;
		logic [ELEM_W-1:0] value;
		product_t known;
	} stim_row_t;

	localparam product_t NO_RESULT = '0;
	localparam product_t SIZE_ERR = '{36'sd0, 4'd0, 1'b0, 1'b0, 1'b1};

	// known expectations: mismatch errors, most negative operands, tiny matrix after clamping
	stim_row_t dir_table [21] = '{
		'{ROW_WRITE, REG_INNER_B, OP_LOAD_B, 16'd4, NO_RESULT},
		'{ROW_KNOWN, REG_ROWS_A, OP_STREAM_A, 16'h7fff, SIZE_ERR},
		'{ROW_KNOWN, REG_ROWS_A, OP_STREAM_A, 16'h8000, SIZE_ERR},
		'{ROW_REQUEST, REG_ROWS_A, OP_LOAD_B, 16'h0000, NO_RESULT},
		'{ROW_WRITE, REG_ROWS_A, OP_LOAD_B, 16'd2, NO_RESULT},
		'{ROW_WRITE, REG_INNER_A, OP_LOAD_B, 16'd2, NO_RESULT},
		'{ROW_WRITE, REG_INNER_B, OP_LOAD_B, 16'd2, NO_RESULT},
		'{ROW_WRITE, REG_COLS_B, OP_LOAD_B, 16'd1, NO_RESULT},
		'{ROW_REQUEST, REG_ROWS_A, OP_LOAD_B, 16'h8000, NO_RESULT},
		'{ROW_REQUEST, REG_ROWS_A, OP_LOAD_B, 16'h8000, NO_RESULT},
		'{ROW_REQUEST, REG_ROWS_A, OP_STREAM_A, 16'h8000, NO_RESULT},
		'{ROW_KNOWN, REG_ROWS_A, OP_STREAM_A, 16'h8000,
			'{36'sh0_8000_0000, 4'd0, 1'b1, 1'b0, 1'b0}},
		'{ROW_REQUEST, REG_ROWS_A, OP_STREAM_A, 16'h7fff, NO_RESULT},
		'{ROW_KNOWN, REG_ROWS_A, OP_STREAM_A, 16'h8000,
			'{36'sh0_0000_8000, 4'd0, 1'b1, 1'b1, 1'b0}},
		'{ROW_REQUEST, REG_ROWS_A, OP_STREAM_A, 16'h0001, NO_RESULT},
		'{ROW_WRITE, REG_INNER_A, OP_LOAD_B, 16'd0, NO_RESULT},
		'{ROW_WRITE, REG_INNER_B, OP_LOAD_B, 16'd0, NO_RESULT},
		'{ROW_WRITE, REG_COLS_B, OP_LOAD_B, 16'd0, NO_RESULT},
		'{ROW_WRITE, REG_ROWS_A, OP_LOAD_B, 16'd0, NO_RESULT},
		'{ROW_REQUEST, REG_ROWS_A, OP_LOAD_B, 16'h0100, NO_RESULT},
		'{ROW_KNOWN, REG_ROWS_A, OP_STREAM_A, 16'hffff,
			'{36'shf_ffff_ff00, 4'd0, 1'b1, 1'b1, 1'b0}}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mmr_in_if items();
	mmr_out_if results();

	matrix_multiply_rows u_top (
		.clk(clk),
		.arst_n(arst_n),
		.items(items),
		.results(results),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	logic [7:0] rows_reg = 8'd1;
	logic [4:0] inner_a_reg = 5'd16;
	logic [4:0] inner_b_reg = 5'd16;
	logic [4:0] cols_reg = 5'd16;
	logic signed [ELEM_W-1:0] b_store [256];
	logic signed [ELEM_W-1:0] a_row [16];
	int unsigned b_pos = 0;
	int unsigned a_pos = 0;
	int unsigned row_num = 0;

	product_t row_out [$];
	product_t expected_products [$];
	product_t want;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned requests_sent = 0;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int unsigned eff_size(input logic [4:0] v);
		if (v == 5'd0)
			return 1;
		if (v > 5'd16)
			return 16;
		return v;
	endfunction

	function automatic void model_write(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_ROWS_A: rows_reg = data;
			REG_INNER_A: inner_a_reg = data[4:0];
			REG_INNER_B: inner_b_reg = data[4:0];
			REG_COLS_B: cols_reg = data[4:0];
			default: ;
		endcase
	endfunction

	// fills row_out with the results one request causes
	function automatic void model_request(input logic op, input logic [ELEM_W-1:0] val);
		int unsigned cols;
		int unsigned inner;
		int unsigned limit;
		int unsigned rows;
		int unsigned j;
		int unsigned k;
		longint acc;
		logic last_row;
		product_t p;
		row_out.delete();
		cols = eff_size(cols_reg);
		if (op == OP_LOAD_B) begin
			limit = eff_size(inner_b_reg) * cols;
			if (b_pos >= limit)
				b_pos = 0;
			b_store[b_pos] = val;
			b_pos++;
			if (b_pos >= limit)
				b_pos = 0;
			return;
		end
		if (inner_a_reg != inner_b_reg) begin
			row_out.push_back(SIZE_ERR);
			return;
		end
		inner = eff_size(inner_a_reg);
		rows = (rows_reg == 8'd0) ? 1 : rows_reg;
		if (a_pos >= inner)
			a_pos = 0;
		a_row[a_pos] = val;
		a_pos++;
		if (a_pos < inner)
			return;
		a_pos = 0;
		if (row_num >= rows)
			row_num = 0;
		last_row = (row_num == rows - 1);
		row_num++;
		if (row_num >= rows)
			row_num = 0;
		for (j = 0; j < cols; j++) begin
			acc = 0;
			for (k = 0; k < inner; k++)
				acc += longint'(a_row[k]) * longint'(b_store[k * cols + j]);
			p.sum = acc[SUM_W-1:0];
			p.col = j[COL_IDX_W-1:0];
			p.row_end = (j == cols - 1);
			p.matrix_end = (j == cols - 1) && last_row;
			p.err = 1'b0;
			row_out.push_back(p);
		end
	endfunction

	function automatic logic [ELEM_W-1:0] rand_value();
		case ($urandom_range(0, 7))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void set_idle(input int unsigned mode);
		case (mode)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 68;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 68;
			end
			default: begin
				send_idle_pct = 20;
				recv_stall_pct = 20;
			end
		endcase
	endfunction

	task automatic flag_mismatch(input string what);
		mismatches++;
		if (mismatches <= 100)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	task automatic push_request(input logic op, input logic [ELEM_W-1:0] val,
		input logic use_known, input product_t known);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			items.valid <= 1'b0;
			@(negedge clk);
		end
		items.valid <= 1'b1;
		items.opcode <= op;
		items.element_value <= val;
		@(posedge clk);
		while (!items.ready)
			@(posedge clk);
		model_request(op, val);
		if (use_known)
			expected_products.push_back(known);
		else
			foreach (row_out[i])
				expected_products.push_back(row_out[i]);
		requests_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		items.valid <= 1'b0;
		while (expected_products.size() != 0)
			@(posedge clk);
	endtask

	// idle block: also covers requests that cause no result
	task automatic settle();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		model_write(idx, data);
	endtask

	always @(negedge clk)
		results.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

	always @(posedge clk) begin
		if (arst_n && results.valid && results.ready) begin
			if (expected_products.size() == 0) begin
				flag_mismatch($sformatf("unexpected result sum %0d col %0d",
					results.product_sum, results.column_index));
			end else begin
				want = expected_products.pop_front();
				if (results.product_sum !== want.sum)
					flag_mismatch($sformatf("product_sum got %0d want %0d",
						results.product_sum, $signed(want.sum)));
				if (results.column_index !== want.col)
					flag_mismatch($sformatf("column_index got %0d want %0d",
						results.column_index, want.col));
				if (results.last_of_row !== want.row_end)
					flag_mismatch($sformatf("last_of_row got %b want %b",
						results.last_of_row, want.row_end));
				if (results.last_of_matrix !== want.matrix_end)
					flag_mismatch($sformatf("last_of_matrix got %b want %b",
						results.last_of_matrix, want.matrix_end));
				if (results.size_error !== want.err)
					flag_mismatch($sformatf("size_error got %b want %b",
						results.size_error, want.err));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int unsigned phase;
		int unsigned first_req;
		int unsigned inner;
		int unsigned cols;
		int unsigned limit;
		int unsigned n_rows;
		logic [4:0] ia;
		logic [4:0] ib;
		logic [4:0] cb;
		logic [7:0] ra;
		logic size_clash;
		row_kind_e prev_kind;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		items.valid = 1'b0;
		items.opcode = OP_LOAD_B;
		items.element_value = '0;
		results.ready = 1'b1;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		prev_kind = ROW_REQUEST;
		foreach (dir_table[i]) begin
			if (dir_table[i].kind == ROW_WRITE) begin
				if (prev_kind != ROW_WRITE)
					settle();
				write_reg(dir_table[i].index, dir_table[i].value[CFG_DATA_W-1:0]);
			end else
				push_request(dir_table[i].op, dir_table[i].value,
					dir_table[i].kind == ROW_KNOWN, dir_table[i].known);
			prev_kind = dir_table[i].kind;
		end

		first_req = requests_sent;
		phase = 0;
		while (requests_sent - first_req < RANDOM_REQUESTS) begin
			size_clash = 1'b0;
			if (phase == 0) begin
				ra = 8'd255;
				ia = 5'd1;
				ib = 5'd1;
				cb = 5'd16;
			end else if (phase == 1) begin
				ra = 8'd3;
				ia = 5'd31;
				ib = 5'd31;
				cb = 5'd1;
			end else begin
				ra = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
				do begin
					ia = 5'($urandom);
					cb = 5'($urandom);
				end while (eff_size(ia) * eff_size(cb) > 64);
				ib = ia;
				if ($urandom_range(0, 4) == 0) begin
					ib = ia ^ 5'($urandom_range(1, 31));
					size_clash = 1'b1;
				end
			end
			settle();
			write_reg(REG_ROWS_A, ra);
			write_reg(REG_INNER_A, {3'($urandom), ia});
			write_reg(REG_INNER_B, {3'($urandom), ib});
			write_reg(REG_COLS_B, {3'($urandom), cb});
			set_idle(phase % 4);

			inner = eff_size(ia);
			cols = eff_size(cb);
			limit = eff_size(ib) * cols;
			if (size_clash) begin
				repeat ($urandom_range(4, 12))
					push_request(($urandom_range(0, 3) != 0) ? OP_STREAM_A : OP_LOAD_B,
						rand_value(), 1'b0, NO_RESULT);
			end else begin
				// whole right matrix first so no unwritten entry is ever read
				repeat (limit)
					push_request(OP_LOAD_B, rand_value(), 1'b0, NO_RESULT);
				n_rows = $urandom_range(1, 6);
				for (int unsigned r = 0; r < n_rows; r++) begin
					for (int unsigned k = 0; k < inner; k++) begin
						if ($urandom_range(0, 19) == 0)
							push_request(OP_LOAD_B, rand_value(), 1'b0, NO_RESULT);
						push_request(OP_STREAM_A, rand_value(), 1'b0, NO_RESULT);
					end
					// hold off until the block has emptied
					if (phase % 3 == 1 && r == 0)
						drain();
				end
				// send one to inner more A elements; fewer than inner leave a partial row for the next setting
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, inner))
						push_request(OP_STREAM_A, rand_value(), 1'b0, NO_RESULT);
			end
			phase++;
		end

		drain();
		repeat (60) @(posedge clk);
		if (expected_products.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", expected_products.size()));
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== matrix_multiply_rows.f =====
hw/rtl/mmr_pkg.sv
hw/rtl/mmr_if.sv
hw/rtl/mmr_queue.sv
hw/rtl/mmr_front.sv
hw/rtl/mmr_back.sv
hw/rtl/matrix_multiply_rows.sv
tb/matrix_multiply_rows_tb.sv
